// ===== design/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and codes for the IPv4 longest prefix router
// Request and result structures, operation and status codes, the stored route
// entry layout and the control state encoding.
// ----------------------------------------------------------------------------
package lpr_pkg;

	typedef enum logic {
		ACT_ADD   = 1'b0,
		ACT_ROUTE = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		STAT_FORWARDED = 3'd0,
		STAT_TTL_DROP  = 3'd1,
		STAT_NO_ROUTE  = 3'd2,
		STAT_ADDED     = 3'd3,
		STAT_FULL      = 3'd4
	} status_t;

	typedef struct packed {
		action_t     action;
		logic [31:0] prefix_value;
		logic [5:0]  prefix_len;
		logic        hop_present;
		logic [31:0] hop_address;
		logic [2:0]  port_index;
		logic [31:0] dest_address;
		logic [7:0]  ttl_in;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [2:0]  out_port;
		logic [31:0] out_hop_address;
		logic [7:0]  ttl_out;
	} rsp_t;

	// One stored route as it sits in the table memory.
	typedef struct packed {
		logic [31:0] prefix;
		logic [5:0]  len;
		logic        has_hop;
		logic [31:0] hop;
		logic [2:0]  port;
	} entry_t;

	// Running best match of a scan.
	typedef struct packed {
		logic        found;
		logic [5:0]  len;
		logic        has_hop;
		logic [31:0] hop;
		logic [2:0]  port;
	} best_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} state_t;

	localparam logic [5:0] MAX_PREFIX_LEN = 6'd32;
	localparam logic [7:0] TTL_MIN_FWD    = 8'd2;

endpackage

// ===== design/lpr_ram.sv =====
// ----------------------------------------------------------------------------
// lpr_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module lpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/lpr_match.sv =====
// ----------------------------------------------------------------------------
// lpr_match: prefix compare and best-match update for one table entry
// Checks one entry read from the table against the destination and decides
// whether it replaces the running best (longer or equal length wins).
// ----------------------------------------------------------------------------
module lpr_match (
	input  lpr_pkg::entry_t entry,
	input  logic [31:0]     dest,
	input  lpr_pkg::best_t  best,
	output logic            take
);
	import lpr_pkg::*;

	logic [31:0] mask;
	logic        hit;

	// Stored lengths never exceed 32, so a right shift of all ones covers
	// every case including the zero-length default route.
	assign mask = ~(32'hFFFF_FFFF >> entry.len);
	assign hit  = ((entry.prefix ^ dest) & mask) == 32'd0;
	assign take = hit && (!best.found || (entry.len >= best.len));

endmodule

// ===== design/ipv4_longest_prefix_router.sv =====
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_router: route table with longest prefix match lookup
// Stores routes in a table memory and scans it once per lookup.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on a rising edge with start high and busy low. The
//   req struct selects adding a route or routing a datagram.
//   Each transaction gives exactly one result on rsp, valid for one cycle
//   while done is high. The receiver cannot stall; it must take the result in
//   that cycle.
//   Adding a route, a table-full report, a TTL drop and a lookup into an
//   empty table all skip the scan: done is high the cycle after start.
//   A lookup otherwise reads the stored routes one per cycle through the
//   table memory port, then registers its result into rsp and raises done.
//   busy is high while the scan runs, and a new
//   transaction can be taken in the cycle that done is high.
//   The entry count is cleared by reset; table contents are not, and only
//   entries below the count are ever used in a match.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_router #(
	parameter int TABLE_DEPTH = 64,
	parameter int PORT_COUNT  = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  lpr_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output lpr_pkg::rsp_t rsp
);
	import lpr_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(TABLE_DEPTH);
	localparam logic [8:0]    PORT_LIM = 9'(PORT_COUNT);
	localparam logic [8:0]    PORT_MAX = 9'(PORT_COUNT - 1);

	state_t        state_q, state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic          valid_s1;
	logic [31:0]   dest_q;
	logic [7:0]    ttl_q;
	best_t         best_q;
	logic          done_q;
	rsp_t          rsp_q;

	logic          accept;
	logic          issue;
	logic          finish;
	logic          go_scan;
	logic          room;
	logic          take;
	logic          ram_we;
	entry_t        wr_entry;
	entry_t        rd_entry;
	logic [2:0]    port_sat;
	logic [5:0]    len_sat;

	assign room  = count_q < DEPTH_C;
	assign issue = rd_idx_q != count_q;

	assign len_sat  = (req.prefix_len > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN : req.prefix_len;
	assign port_sat = ({6'd0, req.port_index} >= PORT_LIM) ? PORT_MAX[2:0] : req.port_index;

	assign wr_entry = '{prefix: req.prefix_value, len: len_sat, has_hop: req.hop_present,
		hop: req.hop_address, port: port_sat};

	// A lookup goes to the scan only when it can actually find something.
	assign go_scan = (req.action == ACT_ROUTE) && (req.ttl_in >= TTL_MIN_FWD)
		&& (count_q != '0);

	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		accept  = 1'b0;
		finish  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				accept = start;
				if (start && go_scan) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				busy = 1'b1;
				if (!issue && !valid_s1) begin
					finish  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign ram_we = accept && (req.action == ACT_ADD) && room;

	lpr_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(wr_entry),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(rd_entry)
	);

	lpr_match u_match (
		.entry(rd_entry),
		.dest (dest_q),
		.best (best_q),
		.take (take)
	);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			rd_idx_q   <= '0;
			valid_s1   <= 1'b0;
			best_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= (accept && !go_scan) || finish;
			if (ram_we) begin
				count_q <= count_q + 1'b1;
			end
			if (accept) begin
				rd_idx_q     <= '0;
				valid_s1     <= 1'b0;
				best_q.found <= 1'b0;
			end else if (state_q == S_SCAN) begin
				valid_s1 <= issue;
				if (issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (valid_s1 && take) begin
					best_q <= '{found: 1'b1, len: rd_entry.len, has_hop: rd_entry.has_hop,
						hop: rd_entry.hop, port: rd_entry.port};
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			dest_q <= req.dest_address;
			ttl_q  <= req.ttl_in;
		end
		if (accept && !go_scan) begin
			rsp_q.out_port        <= 3'd0;
			rsp_q.out_hop_address <= 32'd0;
			rsp_q.ttl_out         <= 8'd0;
			priority if (req.action == ACT_ADD) begin
				rsp_q.status <= room ? STAT_ADDED : STAT_FULL;
			end else if (req.ttl_in < TTL_MIN_FWD) begin
				rsp_q.status <= STAT_TTL_DROP;
			end else begin
				rsp_q.status <= STAT_NO_ROUTE;
			end
		end else if (finish) begin
			if (best_q.found) begin
				rsp_q <= '{status: STAT_FORWARDED, out_port: best_q.port,
					out_hop_address: best_q.has_hop ? best_q.hop : dest_q,
					ttl_out: ttl_q - 8'd1};
			end else begin
				rsp_q <= '{status: STAT_NO_ROUTE, out_port: 3'd0, out_hop_address: 32'd0,
					ttl_out: 8'd0};
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("route count exceeds table depth");

	a_add_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.action == ACT_ADD && count_q < DEPTH_C)
		|=> count_q == $past(count_q) + 1'b1)
		else $error("accepted route add did not advance the count");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> state_q == S_SCAN)
		else $error("table read data pending outside a scan");

	a_fwd_ttl: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == STAT_FORWARDED) |-> rsp.ttl_out != 8'd0)
		else $error("forwarded datagram with expired ttl");
`endif

endmodule

// ===== bench/lpr_route_checker.sv =====
// ----------------------------------------------------------------------------
// lpr_route_checker: result checker for the IPv4 longest prefix router
// Watches the request and result channels, keeps its own copy of the route
// table, predicts the result of every accepted transaction and compares each
// result field by field, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module lpr_route_checker #(
	parameter int TABLE_DEPTH = 64,
	parameter int PORT_COUNT  = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  lpr_pkg::req_t req,
	input  logic          done,
	input  lpr_pkg::rsp_t rsp,
	output int            mismatches,
	output int            results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	import lpr_pkg::*;

	entry_t      route_table [TABLE_DEPTH];
	int unsigned route_count = 0;
	rsp_t        expected_results[$];
	int          fail_count = 0;
	int          due_count = 0;

	assign mismatches  = fail_count;
	assign results_due = due_count;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	// Applies one request to the table copy and returns the result it must give.
	function automatic rsp_t route_table_result(input req_t r);
		rsp_t        res;
		entry_t      e;
		logic        found;
		logic [5:0]  best_len;
		logic [31:0] mask;
		int          best;
		res = '0;
		found = 1'b0;
		best_len = '0;
		best = 0;
		if (r.action == ACT_ADD) begin
			if (route_count >= TABLE_DEPTH) begin
				res.status = STAT_FULL;
			end else begin
				e.prefix  = r.prefix_value;
				e.len     = (r.prefix_len > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN : r.prefix_len;
				e.has_hop = r.hop_present;
				e.hop     = r.hop_address;
				e.port    = (int'(r.port_index) >= PORT_COUNT) ? 3'(PORT_COUNT - 1)
					: r.port_index;
				route_table[route_count] = e;
				route_count++;
				res.status = STAT_ADDED;
			end
		end else if (r.ttl_in < TTL_MIN_FWD) begin
			res.status = STAT_TTL_DROP;
		end else begin
			for (int i = 0; i < route_count; i++) begin
				e = route_table[i];
				mask = (e.len == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (32 - int'(e.len)));
				// Equal lengths favor the later entry, hence the >= test.
				if ((((e.prefix ^ r.dest_address) & mask) == 32'd0) &&
						(!found || e.len >= best_len)) begin
					found = 1'b1;
					best = i;
					best_len = e.len;
				end
			end
			if (!found) begin
				res.status = STAT_NO_ROUTE;
			end else begin
				e = route_table[best];
				res.status          = STAT_FORWARDED;
				res.out_port        = e.port;
				res.out_hop_address = e.has_hop ? e.hop : r.dest_address;
				res.ttl_out         = r.ttl_in - 8'd1;
			end
		end
		return res;
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			// A result always belongs to an earlier transaction than one taken now.
			if (done) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no transaction pending, status",
						32'(rsp.status), '0);
				end else begin
					want = expected_results.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 32'(rsp.status), 32'(want.status));
					if (rsp.out_port !== want.out_port)
						report_mismatch("out_port", 32'(rsp.out_port), 32'(want.out_port));
					if (rsp.out_hop_address !== want.out_hop_address)
						report_mismatch("out_hop_address", rsp.out_hop_address,
							want.out_hop_address);
					if (rsp.ttl_out !== want.ttl_out)
						report_mismatch("ttl_out", 32'(rsp.ttl_out), 32'(want.ttl_out));
				end
			end
			if (start && !busy)
				expected_results.insert(expected_results.size(), route_table_result(req));
			due_count = expected_results.size();
		end
	end

endmodule

// ===== bench/ipv4_longest_prefix_router_tb.sv =====
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_router_tb: regression bench for the prefix router
// Drives a directed set of route adds and lookups, then a long random mix in
// bursts with random gaps; lookups mostly aim at stored prefixes so that
// matches, ties and the full table are reached. The checker does the scoring.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_router_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lpr_pkg::*;

	localparam int TABLE_DEPTH  = 64;
	localparam int PORT_COUNT   = 8;
	localparam int RANDOM_ITEMS = 1400;
	localparam int CYCLE_LIMIT  = 1_000_000;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	logic  done;
	req_t  req;
	rsp_t  rsp;
	int    mismatches;
	int    results_due;
	int    cycle_count = 0;
	int    burst_left;

	// Prefixes stored so far, kept only to aim lookups and tie adds at them.
	logic [31:0] known_prefix [TABLE_DEPTH];
	logic [5:0]  known_len    [TABLE_DEPTH];
	int          routes_added = 0;

	ipv4_longest_prefix_router #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.PORT_COUNT (PORT_COUNT)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.busy  (busy),
		.done  (done),
		.rsp   (rsp)
	);

	lpr_route_checker #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.PORT_COUNT (PORT_COUNT)
	) route_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.rsp        (rsp),
		.mismatches (mismatches),
		.results_due(results_due)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ipv4_longest_prefix_router regression: fail");
			$finish;
		end
	end

	function automatic logic [31:0] len_to_mask(input logic [5:0] len);
		if (len == 6'd0)
			return 32'd0;
		return 32'hFFFF_FFFF << (32 - int'(len));
	endfunction

	function automatic req_t noise_item();
		req_t r;
		r.action       = action_t'($urandom_range(0, 1));
		r.prefix_value = $urandom();
		r.prefix_len   = 6'($urandom_range(0, 63));
		r.hop_present  = 1'($urandom_range(0, 1));
		r.hop_address  = $urandom();
		r.port_index   = 3'($urandom_range(0, 7));
		r.dest_address = $urandom();
		r.ttl_in       = 8'($urandom_range(0, 255));
		return r;
	endfunction

	function automatic req_t route_add_req(input logic [31:0] pfx, input logic [5:0] len,
			input logic has_hop, input logic [31:0] hop, input logic [2:0] port);
		req_t r;
		r = noise_item();
		r.action       = ACT_ADD;
		r.prefix_value = pfx;
		r.prefix_len   = len;
		r.hop_present  = has_hop;
		r.hop_address  = hop;
		r.port_index   = port;
		return r;
	endfunction

	function automatic req_t route_packet(input logic [31:0] dst, input logic [7:0] ttl);
		req_t r;
		r = noise_item();
		r.action       = ACT_ROUTE;
		r.dest_address = dst;
		r.ttl_in       = ttl;
		return r;
	endfunction

	// Holds the request until it is taken, then maybe leaves a gap in the burst.
	task automatic send_item(input req_t r);
		int gap;
		req   <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (r.action == ACT_ADD && routes_added < TABLE_DEPTH) begin
			known_prefix[routes_added] = r.prefix_value;
			known_len[routes_added]    = (r.prefix_len > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN
				: r.prefix_len;
			routes_added++;
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		req        = '0;
		burst_left = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Lookups into the empty table, then a small table with nested prefixes.
		send_item(route_packet(32'h0A01_0203, 8'd64));
		send_item(route_packet(32'h0A01_0203, 8'd0));
		send_item(route_packet(32'h0A01_0203, 8'd1));
		send_item(route_add_req(32'h0A00_0000, 6'd8, 1'b0, 32'h1234_5678, 3'd1));
		send_item(route_add_req(32'h0A01_0000, 6'd16, 1'b1, 32'hC0A8_0001, 3'd2));
		send_item(route_add_req(32'h0A01_0203, 6'd45, 1'b1, 32'hC0A8_0002, 3'd7));
		// Same /16 again with junk in the low bits; it must win the tie.
		send_item(route_add_req(32'h0A01_FFFF, 6'd16, 1'b1, 32'hC0A8_0003, 3'd3));
		send_item(route_packet(32'h0A01_0203, 8'd255));
		send_item(route_packet(32'h0A01_0909, 8'd2));
		send_item(route_packet(32'h0AC8_0001, 8'd100));
		send_item(route_packet(32'h0B00_0000, 8'd9));
		send_item(route_packet(32'h0000_0000, 8'd255));
		send_item(route_add_req(32'hFFFF_FFFF, 6'd63, 1'b1, 32'hFFFF_FFFF, 3'd6));
		send_item(route_packet(32'hFFFF_FFFF, 8'd255));
		send_item(route_add_req(32'h8000_0000, 6'd1, 1'b0, 32'h0000_0000, 3'd0));
		send_item(route_packet(32'h8000_0001, 8'd2));
		send_item(route_packet(32'hFFFF_FFFF, 8'd1));
		send_item(route_packet(32'hFFFF_FFFE, 8'd0));
		send_item(route_add_req(32'h0000_0000, 6'd32, 1'b1, 32'h0000_0000, 3'd5));
		send_item(route_packet(32'h0000_0000, 8'd128));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			req_t        r;
			int          k;
			logic [31:0] m;
			r = noise_item();
			if ($urandom_range(0, 99) < 11) begin
				r.action = ACT_ADD;
				// A default route is added once, late, so that misses stay possible
				// for most of the run.
				if (routes_added == 50) begin
					r.prefix_len = 6'd0;
				end else if (routes_added > 0 && $urandom_range(0, 4) == 0) begin
					k = $urandom_range(0, routes_added - 1);
					r.prefix_len   = known_len[k];
					r.prefix_value = known_prefix[k] ^ ($urandom() & ~len_to_mask(known_len[k]));
				end else if ($urandom_range(0, 6) == 0) begin
					r.prefix_len = 6'($urandom_range(33, 63));
				end else begin
					r.prefix_len = 6'($urandom_range(1, 32));
				end
			end else begin
				r.action = ACT_ROUTE;
				if ($urandom_range(0, 9) == 0)
					r.ttl_in = 8'($urandom_range(0, 1));
				if (routes_added > 0 && $urandom_range(0, 3) != 0) begin
					k = $urandom_range(0, routes_added - 1);
					m = len_to_mask(known_len[k]);
					r.dest_address = (known_prefix[k] & m) | (r.dest_address & ~m);
				end
			end
			send_item(r);
		end
		start <= 1'b0;

		do @(negedge clk); while (results_due != 0);
		repeat (TABLE_DEPTH + 4) @(posedge clk);
		if (mismatches == 0)
			$display("ipv4_longest_prefix_router regression: pass");
		else
			$display("ipv4_longest_prefix_router regression: fail");
		$finish;
	end

endmodule
